// File: sv/puct_pkg.sv
// Shared types and constants for the PUCT action selection block.
// Used by puct_div, puct_ctrl, puct_dp and puct_action_select; depends on nothing.
package puct_pkg;

   localparam int MAX_ACTIONS = 64;
   localparam int IDX_W       = $clog2(MAX_ACTIONS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int VAL_W       = 32;
   localparam int PRI_W       = 17;
   localparam int VIS_W       = 20;
   localparam int TOT_W       = 26;
   localparam int GAIN_W      = 16;
   localparam int SCORE_W     = 32;
   localparam int ENTRY_W     = VAL_W + PRI_W + VIS_W;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;
   localparam int RANGE_W     = VAL_W + 1;
   localparam int T_W         = 25;
   localparam int ROOT_W      = 30;
   localparam int PROD_W      = T_W + ROOT_W;
   localparam int RX_W        = 59;
   localparam int DIV_NW      = 39;
   localparam int DIV_DW      = 33;
   localparam int DIV_CW      = 6;
   localparam int QN_W        = 17;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd320;
   localparam logic [TOT_W-1:0]  TOTAL_MAX   = '1;
   localparam logic [QN_W-1:0]   QN_HALF     = 17'd32768;
   localparam logic [DIV_CW-1:0] QN_STEPS    = 6'd17;
   localparam logic [DIV_CW-1:0] U_STEPS     = 6'd39;
   localparam logic [RX_W-1:0]   ROOT_B_INIT = 59'd1 << 58;

   typedef enum logic [8:0] {
      ST_LOAD   = 9'b000000001,
      ST_ROOT   = 9'b000000010,
      ST_READ   = 9'b000000100,
      ST_MUL1   = 9'b000001000,
      ST_MUL2   = 9'b000010000,
      ST_DIV_GO = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_CMP    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic accept_en;
      logic root_go;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic mul1_en;
      logic mul2_en;
      logic div_go;
      logic cmp_en;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_fire;
      logic root_busy;
      logic div_busy;
      logic idx_last;
      logic out_busy;
   } status_type;

endpackage

// File: sv/puct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module puct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// File: sv/puct_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on puct_pkg for widths.
module puct_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [puct_pkg::DIV_DW-1:0] rem_init,
   input  logic [puct_pkg::DIV_NW-1:0] bits,
   input  logic [puct_pkg::DIV_CW-1:0] steps,
   input  logic [puct_pkg::DIV_DW-1:0] divisor,
   output logic                        busy,
   output logic [puct_pkg::DIV_NW-1:0] quot
);
   import puct_pkg::*;

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] sh_ff, sh_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW-1:0] d_ff;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW:0]   trial;

   assign busy = (cnt_ff != '0);
   assign quot = q_ff;
   assign trial = {rem_ff, sh_ff[DIV_NW-1]} - {1'b0, d_ff};

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         sh_in  = bits;
         q_in   = '0;
         cnt_in = steps;
      end else if (busy) begin
         sh_in  = {sh_ff[DIV_NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (!trial[DIV_DW]) begin
            rem_in = trial[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_DW-2:0], sh_ff[DIV_NW-1]};
            q_in   = {q_ff[DIV_NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      if (start) begin
         d_ff <= divisor;
      end
   end
endmodule

// File: sv/puct_ctrl.sv
// Controller state machine: loading, square root, per-action scoring, emit.
// Depends on puct_pkg for the state, command and status types.
module puct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  puct_pkg::status_type status,
   output puct_pkg::cmd_type    cmd
);
   import puct_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.accept_en = 1'b1;
            if (status.last_fire) begin
               cmd.root_go = 1'b1;
               state_in    = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.idx_clr = 1'b1;
            if (!status.root_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1_en = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2_en = 1'b1;
            state_in    = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp_en = 1'b1;
            if (status.idx_last) begin
               state_in = ST_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: sv/puct_dp.sv
// Datapath: entry store, node statistics, square root, scoring, result register.
// Depends on puct_pkg, puct_ram and puct_div.
module puct_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  puct_pkg::cmd_type               cmd,
   output puct_pkg::status_type            status,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [puct_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [puct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [puct_pkg::GAIN_W-1:0]     csr_data
);
   import puct_pkg::*;

   logic              fire, store;
   logic [VAL_W-1:0]  in_value;
   logic [VIS_W-1:0]  in_visit;
   logic [ENTRY_W-1:0] rd_entry;

   logic [GAIN_W-1:0] gain_ff;
   logic [CNT_W-1:0]  loaded_ff;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W:0]    total_sum;
   logic signed [VAL_W-1:0] low_ff, high_ff;
   logic [RANGE_W-1:0] range;
   logic              range_zero;

   logic [RX_W-1:0]   rx_ff, rb_ff;
   logic [RX_W:0]     rr_ff, rsum;
   logic [ROOT_W-1:0] root_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [RANGE_W-1:0] diff_ff;
   logic [T_W-1:0]    t_ff;
   logic [VIS_W-1:0]  visit_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [2*GAIN_W:0] gp;
   logic [VIS_W:0]    visit_inc;

   logic              qdiv_busy, udiv_busy;
   logic [DIV_NW-1:0] qdiv_q, udiv_q;
   logic [QN_W-1:0]   qn;
   logic [DIV_NW:0]   score_sum;
   logic [SCORE_W-1:0] score;
   logic [SCORE_W-1:0] best_s_ff;
   logic [IDX_W-1:0]  best_i_ff;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign in_value   = req_tdata[VAL_W-1:0];
   assign in_visit   = req_tdata[ENTRY_W-1:VAL_W+PRI_W];
   assign req_tready = cmd.accept_en;
   assign fire       = req_tvalid && req_tready;
   assign store      = fire && !loaded_ff[CNT_W-1];
   assign csr_ready  = 1'b1;

   puct_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ACTIONS)) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (loaded_ff[IDX_W-1:0]),
      .wr_data (req_tdata[ENTRY_W-1:0]),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   assign total_sum  = {1'b0, total_ff} + {{(TOT_W+1-VIS_W){1'b0}}, in_visit};
   assign range      = {high_ff[VAL_W-1], high_ff} - {low_ff[VAL_W-1], low_ff};
   assign range_zero = (high_ff == low_ff);

   always_comb begin
      total_in = total_ff;
      if (store) begin
         total_in = total_sum[TOT_W] ? TOTAL_MAX : total_sum[TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         loaded_ff <= '0;
         total_ff  <= '0;
         low_ff    <= {1'b0, {(VAL_W-1){1'b1}}};
         high_ff   <= {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         if (csr_valid && csr_ready) begin
            gain_ff <= csr_data;
         end
         if (cmd.emit) begin
            loaded_ff <= '0;
            total_ff  <= '0;
            low_ff    <= {1'b0, {(VAL_W-1){1'b1}}};
            high_ff   <= {1'b1, {(VAL_W-1){1'b0}}};
         end else if (store) begin
            loaded_ff <= loaded_ff + 1'b1;
            total_ff  <= total_in;
            if ($signed(in_value) < low_ff) begin
               low_ff <= in_value;
            end
            if ($signed(in_value) > high_ff) begin
               high_ff <= in_value;
            end
         end
      end
   end

   // square root of (total + 1) * 2^32, two result bits per step pair
   assign rsum = rr_ff + {1'b0, rb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff <= '0;
      end else if (cmd.root_go) begin
         rb_ff <= ROOT_B_INIT;
      end else if (rb_ff != '0) begin
         rb_ff <= rb_ff >> 2;
      end
      if (cmd.root_go) begin
         rx_ff <= {({1'b0, total_in} + 1'b1), 32'd0};
         rr_ff <= '0;
      end else if (rb_ff != '0) begin
         if ({1'b0, rx_ff} >= rsum) begin
            rx_ff <= rx_ff - rsum[RX_W-1:0];
            rr_ff <= (rr_ff >> 1) + {1'b0, rb_ff};
         end else begin
            rr_ff <= rr_ff >> 1;
         end
      end
      root_ff <= rr_ff[ROOT_W-1:0];
   end

   assign gp        = gain_ff * rd_entry[VAL_W+PRI_W-1:VAL_W];
   assign visit_inc = {1'b0, visit_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.mul1_en) begin
         diff_ff  <= {rd_entry[VAL_W-1], rd_entry[VAL_W-1:0]} - {low_ff[VAL_W-1], low_ff};
         t_ff     <= gp[T_W+7:8];
         visit_ff <= rd_entry[ENTRY_W-1:VAL_W+PRI_W];
      end
      if (cmd.mul2_en) begin
         prod_ff <= t_ff * root_ff;
      end
   end

   puct_div u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .rem_init ({1'b0, diff_ff[RANGE_W-1:1]}),
      .bits     ({diff_ff[0], {(DIV_NW-1){1'b0}}}),
      .steps    (QN_STEPS),
      .divisor  (range),
      .busy     (qdiv_busy),
      .quot     (qdiv_q)
   );

   puct_div u_udiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .rem_init ('0),
      .bits     (prod_ff[PROD_W-1:16]),
      .steps    (U_STEPS),
      .divisor  ({{(DIV_DW-VIS_W-1){1'b0}}, visit_inc}),
      .busy     (udiv_busy),
      .quot     (udiv_q)
   );

   assign qn        = range_zero ? QN_HALF : qdiv_q[QN_W-1:0];
   assign score_sum = {1'b0, udiv_q} + {{(DIV_NW+1-QN_W){1'b0}}, qn};
   assign score     = (score_sum[DIV_NW:SCORE_W] != '0) ? '1 : score_sum[SCORE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.cmp_en && ((idx_ff == '0) || (score > best_s_ff))) begin
         best_s_ff <= score;
         best_i_ff <= idx_ff;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {{(RSP_DATA_W-SCORE_W-IDX_W){1'b0}}, best_s_ff, best_i_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.last_fire = fire && req_tlast;
      status.root_busy = (rb_ff != '0);
      status.div_busy  = qdiv_busy || udiv_busy;
      status.idx_last  = ({1'b0, idx_ff} + 1'b1) == loaded_ff;
      status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_ACTIONS))
      else $error("entry count above store depth");

   a_root_start: assert property (@(posedge clock) disable iff (reset)
      cmd.root_go |=> (rb_ff == ROOT_B_INIT))
      else $error("root unit did not start");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (loaded_ff == '0) && (total_ff == '0) && rsp_tvalid)
      else $error("node not cleared on emit");
endmodule

// File: sv/puct_action_select.sv
// Top level of the PUCT action selection block.
// Depends on puct_pkg, puct_ctrl and puct_dp.
//
// Usage:
//   req_*: one action entry per transaction; tdata holds mean_value, prior_prob
//          and visit_count, tlast marks the node's final entry. Entries beyond
//          64 are dropped, but their tlast still ends the node.
//   rsp_*: one transaction per node with best_action and top_score.
//   csr_*: explore_gain (Q8.8), always ready; write only while idle.
// Sequence: loading accepts one entry per cycle. After the last entry the square
//   root runs, then each stored action goes through a RAM read, two multiplies,
//   two parallel bit-serial dividers, the longer of 39 steps, and a compare;
//   after the last stored action of the node the result is emitted.
// A result waits in an output register; the next node can load meanwhile and
//   only its emit waits while rsp_tready is low.
// Reset: gain returns to 320, node statistics clear, no result pending.
//   The entry RAM is not cleared; only written entries are read.
module puct_action_select (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] mean_value, [48:32] prior_prob, [68:49] visit_count, zero fill
   input  logic [puct_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] best_action, [37:6] top_score, zero fill
   output logic [puct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [puct_pkg::GAIN_W-1:0]     csr_data
);
   import puct_pkg::*;

   cmd_type    cmd;
   status_type status;

   puct_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   puct_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );
endmodule
